>>> sv/lzbd_pkg.sv
// ----------------------------------------------------------------------------
// lzbd_pkg
// Shared types and constants of the LZSS block decompressor: decode phases,
// sequencer states, and the command and status bundles between controller
// and datapath.
// ----------------------------------------------------------------------------
package lzbd_pkg;

	localparam int IN_W    = 8;
	localparam int DATA_W  = 64;
	localparam int COUNT_W = 4;
	localparam int LEN_W   = 16;
	localparam int DIST_W  = 12;
	localparam int COPY_W  = 9;
	localparam int TDATA_W = 72;
	localparam int TUSER_W = 3;

	localparam logic [IN_W-1:0]    TOKEN_LEN_BASE = 8'h12;
	localparam logic [IN_W-1:0]    FLAG_MSB_MASK  = 8'h80;
	localparam logic [3:0]         FLAGS_PER_BYTE = 4'd8;
	localparam logic [LEN_W-1:0]   COUNT_MAX      = 16'hFFFF;

	// decode phase of the compressed stream
	typedef enum logic [3:0] {
		PH_DLO,
		PH_DHI,
		PH_CLO,
		PH_CHI,
		PH_RAW,
		PH_FIRST,
		PH_FLAG,
		PH_LIT,
		PH_TOKA,
		PH_TOKB,
		PH_EXT
	} phase_t;

	// per-word sequencing
	typedef enum logic [2:0] {
		SQ_IN,
		SQ_CHK,
		SQ_RD,
		SQ_WR,
		SQ_FLUSH
	} seq_t;

	typedef struct packed {
		logic ld_held;
		logic ld_exp;
		logic clr_count;
		logic push_in;
		logic push_mem;
		logic push_final;
		logic push_end;
		logic rd;
		logic ld_dist_hi;
		logic ld_dist_lo;
		logic emit;
		logic emit_end;
		logic emit_bad;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic len_eq;
		logic exp_zero;
		logic prod_next_eq;
		logic lane_busy;
		logic bad_ref;
		logic dist_in_zero;
	} dp_sts_t;

endpackage

>>> sv/lzbd_ctrl.sv
// ----------------------------------------------------------------------------
// lzbd_ctrl
// Controller: tracks the decode phase and flag bits of the compressed
// stream and sequences literal pushes, match copies and result flushes.
// ----------------------------------------------------------------------------
module lzbd_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [lzbd_pkg::IN_W-1:0]      in_byte,
	input  lzbd_pkg::dp_sts_t              sts,
	output lzbd_pkg::dp_cmd_t              cmd
);

	lzbd_pkg::seq_t   seq_q, seq_d;
	lzbd_pkg::phase_t phase_q, phase_d;
	logic [7:0]                    flag_bits_q, flag_bits_d;
	logic [3:0]                    flags_left_q, flags_left_d;
	logic [3:0]                    nibble_q, nibble_d;
	logic [lzbd_pkg::COPY_W-1:0]   copy_left_q, copy_left_d;
	logic                          end_q, end_d;
	logic                          bad_q, bad_d;

	logic [7:0]       fb_shift;
	logic [3:0]       fl_dec;
	lzbd_pkg::phase_t ni_phase;

	// next flag item
	always_comb begin
		fb_shift = {flag_bits_q[6:0], 1'b0};
		fl_dec   = (flags_left_q != 4'd0) ? flags_left_q - 4'd1 : 4'd0;
		if (fl_dec == 4'd0) begin
			ni_phase = lzbd_pkg::PH_FLAG;
		end else if ((fb_shift & lzbd_pkg::FLAG_MSB_MASK) != 8'd0) begin
			ni_phase = lzbd_pkg::PH_TOKA;
		end else begin
			ni_phase = lzbd_pkg::PH_LIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= lzbd_pkg::SQ_IN;
			phase_q      <= lzbd_pkg::PH_DLO;
			flag_bits_q  <= '0;
			flags_left_q <= '0;
			nibble_q     <= '0;
			copy_left_q  <= '0;
			end_q        <= 1'b0;
			bad_q        <= 1'b0;
		end else begin
			seq_q        <= seq_d;
			phase_q      <= phase_d;
			flag_bits_q  <= flag_bits_d;
			flags_left_q <= flags_left_d;
			nibble_q     <= nibble_d;
			copy_left_q  <= copy_left_d;
			end_q        <= end_d;
			bad_q        <= bad_d;
		end
	end

	always_comb begin
		seq_d        = seq_q;
		phase_d      = phase_q;
		flag_bits_d  = flag_bits_q;
		flags_left_d = flags_left_q;
		nibble_d     = nibble_q;
		copy_left_d  = copy_left_q;
		end_d        = end_q;
		bad_d        = bad_q;
		cmd          = '0;
		in_ready     = 1'b0;

		case (seq_q)
			lzbd_pkg::SQ_IN: begin
				in_ready = sts.out_free;
				if (in_valid && sts.out_free) begin
					case (phase_q)
						lzbd_pkg::PH_DHI: begin
							cmd.ld_exp = 1'b1;
							phase_d    = lzbd_pkg::PH_CLO;
						end
						lzbd_pkg::PH_CLO: begin
							cmd.ld_held = 1'b1;
							phase_d     = lzbd_pkg::PH_CHI;
						end
						lzbd_pkg::PH_CHI: begin
							cmd.clr_count = 1'b1;
							if (sts.len_eq) begin
								phase_d = lzbd_pkg::PH_RAW;
								if (sts.exp_zero) begin
									end_d = 1'b1;
									seq_d = lzbd_pkg::SQ_FLUSH;
								end
							end else begin
								phase_d = lzbd_pkg::PH_FIRST;
							end
						end
						lzbd_pkg::PH_RAW: begin
							cmd.push_in    = 1'b1;
							cmd.push_final = 1'b1;
							cmd.push_end   = sts.prod_next_eq;
							end_d          = sts.prod_next_eq;
							seq_d          = lzbd_pkg::SQ_FLUSH;
						end
						lzbd_pkg::PH_FIRST: begin
							cmd.push_in    = 1'b1;
							cmd.push_final = 1'b1;
							phase_d        = lzbd_pkg::PH_FLAG;
							seq_d          = lzbd_pkg::SQ_FLUSH;
						end
						lzbd_pkg::PH_FLAG: begin
							flag_bits_d  = in_byte;
							flags_left_d = lzbd_pkg::FLAGS_PER_BYTE;
							phase_d      = ((in_byte & lzbd_pkg::FLAG_MSB_MASK) != 8'd0) ?
								lzbd_pkg::PH_TOKA : lzbd_pkg::PH_LIT;
						end
						lzbd_pkg::PH_LIT: begin
							cmd.push_in    = 1'b1;
							cmd.push_final = 1'b1;
							flag_bits_d    = fb_shift;
							flags_left_d   = fl_dec;
							phase_d        = ni_phase;
							seq_d          = lzbd_pkg::SQ_FLUSH;
						end
						lzbd_pkg::PH_TOKA: begin
							nibble_d       = in_byte[3:0];
							cmd.ld_dist_hi = 1'b1;
							phase_d        = lzbd_pkg::PH_TOKB;
						end
						lzbd_pkg::PH_TOKB: begin
							cmd.ld_dist_lo = 1'b1;
							if (nibble_q != 4'd0) begin
								copy_left_d  = lzbd_pkg::COPY_W'(lzbd_pkg::TOKEN_LEN_BASE)
									- lzbd_pkg::COPY_W'(nibble_q);
								flag_bits_d  = fb_shift;
								flags_left_d = fl_dec;
								phase_d      = ni_phase;
								seq_d        = lzbd_pkg::SQ_CHK;
							end else if (sts.dist_in_zero) begin
								// end-of-block token
								end_d = 1'b1;
								seq_d = lzbd_pkg::SQ_FLUSH;
							end else begin
								phase_d = lzbd_pkg::PH_EXT;
							end
						end
						lzbd_pkg::PH_EXT: begin
							copy_left_d  = lzbd_pkg::COPY_W'(in_byte)
								+ lzbd_pkg::COPY_W'(lzbd_pkg::TOKEN_LEN_BASE);
							flag_bits_d  = fb_shift;
							flags_left_d = fl_dec;
							phase_d      = ni_phase;
							seq_d        = lzbd_pkg::SQ_CHK;
						end
						default: begin
							cmd.ld_held = 1'b1;
							phase_d     = lzbd_pkg::PH_DHI;
						end
					endcase
				end
			end
			lzbd_pkg::SQ_CHK: begin
				if (sts.bad_ref) begin
					bad_d = 1'b1;
					seq_d = lzbd_pkg::SQ_FLUSH;
				end else begin
					seq_d = lzbd_pkg::SQ_RD;
				end
			end
			lzbd_pkg::SQ_RD: begin
				cmd.rd = 1'b1;
				seq_d  = lzbd_pkg::SQ_WR;
			end
			lzbd_pkg::SQ_WR: begin
				if (sts.out_free) begin
					cmd.push_mem   = 1'b1;
					cmd.push_final = (copy_left_q == lzbd_pkg::COPY_W'(1));
					copy_left_d    = copy_left_q - lzbd_pkg::COPY_W'(1);
					seq_d          = (copy_left_q == lzbd_pkg::COPY_W'(1)) ?
						lzbd_pkg::SQ_FLUSH : lzbd_pkg::SQ_RD;
				end
			end
			lzbd_pkg::SQ_FLUSH: begin
				if (sts.out_free) begin
					if (sts.lane_busy || end_q || bad_q) begin
						cmd.emit     = 1'b1;
						cmd.emit_end = end_q;
						cmd.emit_bad = bad_q;
					end
					if (end_q) begin
						cmd.clr_count = 1'b1;
						phase_d       = lzbd_pkg::PH_DLO;
						flag_bits_d   = '0;
						flags_left_d  = '0;
					end
					end_d = 1'b0;
					bad_d = 1'b0;
					seq_d = lzbd_pkg::SQ_IN;
				end
			end
			default: begin
				seq_d = lzbd_pkg::SQ_IN;
			end
		endcase
	end

	ap_copy_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == lzbd_pkg::SQ_RD) |-> (copy_left_q != '0))
		else $error("match copy running with no bytes left");

	ap_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.push_mem || cmd.push_in) |-> sts.out_free)
		else $error("result issued while output register is occupied");

	ap_copy_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_mem && cmd.push_final) |=> (seq_q == lzbd_pkg::SQ_FLUSH))
		else $error("final copied byte not followed by flush");

endmodule

>>> sv/lzbd_dp.sv
// ----------------------------------------------------------------------------
// lzbd_dp
// Datapath: header lengths, produced count, match distance, history window
// memory, output lane packing and the output register.
// ----------------------------------------------------------------------------
module lzbd_dp #(
	parameter int HISTORY_DEPTH = 4096,
	parameter int LANE_BYTES    = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [lzbd_pkg::IN_W-1:0]         in_byte,
	input  lzbd_pkg::dp_cmd_t                 cmd,
	output lzbd_pkg::dp_sts_t                 sts,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lzbd_pkg::DATA_W-1:0]       out_data,
	output logic [lzbd_pkg::COUNT_W-1:0]      out_count,
	output logic                              out_last,
	output logic                              out_end,
	output logic                              out_mism,
	output logic                              out_bad
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam logic [AW:0] DEPTH_W = (AW+1)'(HISTORY_DEPTH);
	localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);
	localparam logic [lzbd_pkg::COUNT_W-1:0] LANE_CNT = lzbd_pkg::COUNT_W'(LANE_BYTES);

	logic [7:0]                        held_q;
	logic [lzbd_pkg::LEN_W-1:0]        expected_q;
	logic [lzbd_pkg::LEN_W-1:0]        produced_q;
	logic                              pend_q;
	logic [lzbd_pkg::DIST_W-1:0]       dist_q;
	logic [AW-1:0]                     wp_q;
	logic [lzbd_pkg::DATA_W-1:0]       lane_q;
	logic [lzbd_pkg::COUNT_W-1:0]      lane_n_q;
	logic                              out_valid_q;
	logic [lzbd_pkg::DATA_W-1:0]       out_data_q;
	logic [lzbd_pkg::COUNT_W-1:0]      out_count_q;
	logic                              out_last_q;
	logic                              out_end_q;
	logic                              out_mism_q;
	logic                              out_bad_q;

	logic [7:0]                        hist_mem [HISTORY_DEPTH];
	logic [7:0]                        rd_data_q;

	logic                              push;
	logic [7:0]                        push_byte;
	logic [lzbd_pkg::DATA_W-1:0]       lane_next;
	logic                              lane_full;
	logic [lzbd_pkg::LEN_W-1:0]        prod_next;
	logic [AW-1:0]                     dist_ext;
	logic [AW-1:0]                     src_addr;
	logic [AW:0]                       src_wrap;
	logic                              mism_now;
	logic                              emit_full;

	always_comb begin
		push      = cmd.push_in || cmd.push_mem;
		push_byte = cmd.push_in ? in_byte : rd_data_q;
		lane_next = lane_q;
		lane_next[8*lane_n_q[2:0] +: 8] = push_byte;
		lane_full = (lane_n_q + lzbd_pkg::COUNT_W'(1)) == LANE_CNT;
		emit_full = push && lane_full;
		prod_next = (produced_q == lzbd_pkg::COUNT_MAX) ? produced_q : produced_q + 16'd1;
		dist_ext  = AW'(dist_q);
		src_wrap  = {1'b0, wp_q} + DEPTH_W - {1'b0, dist_ext};
		src_addr  = (wp_q >= dist_ext) ? wp_q - dist_ext : src_wrap[AW-1:0];
		mism_now  = pend_q || (produced_q != expected_q);
	end

	always_comb begin
		sts.out_free     = !out_valid_q || out_ready;
		sts.len_eq       = ({in_byte, held_q} == expected_q);
		sts.exp_zero     = (expected_q == '0);
		sts.prod_next_eq = (prod_next == expected_q);
		sts.lane_busy    = (lane_n_q != '0);
		sts.bad_ref      = (dist_q == '0) ||
			(!pend_q && (lzbd_pkg::LEN_W'(dist_q) > produced_q));
		sts.dist_in_zero = (dist_q[11:8] == 4'd0) && (in_byte == 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			expected_q  <= '0;
			produced_q  <= '0;
			pend_q      <= 1'b0;
			dist_q      <= '0;
			wp_q        <= '0;
			lane_q      <= '0;
			lane_n_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ld_held) begin
				held_q <= in_byte;
			end
			if (cmd.ld_exp) begin
				expected_q <= {in_byte, held_q};
			end
			if (cmd.ld_dist_hi) begin
				dist_q <= {in_byte[7:4], 8'd0};
			end
			if (cmd.ld_dist_lo) begin
				dist_q[7:0] <= in_byte;
			end
			if (cmd.clr_count) begin
				produced_q <= '0;
				pend_q     <= 1'b0;
			end else if (push) begin
				produced_q <= prod_next;
				if (produced_q == lzbd_pkg::COUNT_MAX) begin
					pend_q <= 1'b1;
				end
			end
			if (push) begin
				wp_q <= (wp_q == WP_LAST) ? '0 : wp_q + AW'(1);
			end
			// drop the lane once it goes out, either full or on flush
			if (emit_full || cmd.emit) begin
				lane_q   <= '0;
				lane_n_q <= '0;
			end else if (push) begin
				lane_q   <= lane_next;
				lane_n_q <= lane_n_q + lzbd_pkg::COUNT_W'(1);
			end
			if (emit_full || cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_full) begin
			out_data_q  <= lane_next;
			out_count_q <= LANE_CNT;
			out_last_q  <= cmd.push_final && !cmd.push_end;
			out_end_q   <= 1'b0;
			out_mism_q  <= 1'b0;
			out_bad_q   <= 1'b0;
		end else if (cmd.emit) begin
			out_data_q  <= lane_q;
			out_count_q <= lane_n_q;
			out_last_q  <= 1'b1;
			out_end_q   <= cmd.emit_end;
			out_mism_q  <= cmd.emit_end && mism_now;
			out_bad_q   <= cmd.emit_bad;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			hist_mem[wp_q] <= push_byte;
		end
		if (cmd.rd) begin
			rd_data_q <= hist_mem[src_addr];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_count = out_count_q;
	assign out_last  = out_last_q;
	assign out_end   = out_end_q;
	assign out_mism  = out_mism_q;
	assign out_bad   = out_bad_q;

	ap_lane_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lane_n_q < LANE_CNT)
		else $error("lane fill count reached lane width");

	ap_pend_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (produced_q == lzbd_pkg::COUNT_MAX))
		else $error("overflow flag set without saturated count");

	ap_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_full || cmd.emit) |=> out_valid_q)
		else $error("result not presented after emit");

endmodule

>>> sv/lzss_block_decompressor.sv
// ----------------------------------------------------------------------------
// lzss_block_decompressor
// Top level: LZSS block decoder, one compressed byte per input word, decoded
// bytes out in lanes.
// ----------------------------------------------------------------------------
// Decodes back-to-back blocks, each opening with little-endian decompressed
// and compressed 16-bit lengths; equal lengths mean a stored block. Header,
// flag and token bytes need no flush of their own, except that a header or
// token byte closing a block is followed by a flush of its result word. A
// literal or stored byte is accepted and then its result word is flushed. A
// match runs through its last token byte, a check step (a bad reference goes
// straight to the flush), a read and a write of the single-port-read history
// memory per copied byte, and a flush, so a match of up to 273 bytes holds
// s_tready low meanwhile.
// Every result word carries up to LANE_BYTES bytes; tlast marks the last word
// caused by one input byte. Input is also held back while a result waits
// on m_tready. There is no clearing pass after reset.
module lzss_block_decompressor #(
	parameter int HISTORY_DEPTH = 4096,
	parameter int LANE_BYTES    = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [lzbd_pkg::IN_W-1:0]           s_tdata,   // [7:0] in_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [63:0] out_data, [67:64] out_count, [71:68] zero
	output logic [lzbd_pkg::TDATA_W-1:0]        m_tdata,
	output logic                                m_tlast,   // last_of_run
	// [0] block_end, [1] length_mismatch, [2] bad_reference
	output logic [lzbd_pkg::TUSER_W-1:0]        m_tuser
);

	lzbd_pkg::dp_cmd_t cmd;
	lzbd_pkg::dp_sts_t sts;

	logic [lzbd_pkg::DATA_W-1:0]  out_data;
	logic [lzbd_pkg::COUNT_W-1:0] out_count;
	logic                         out_end;
	logic                         out_mism;
	logic                         out_bad;

	lzbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.sts      (sts),
		.cmd      (cmd)
	);

	lzbd_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.LANE_BYTES    (LANE_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data),
		.out_count (out_count),
		.out_last  (m_tlast),
		.out_end   (out_end),
		.out_mism  (out_mism),
		.out_bad   (out_bad)
	);

	assign m_tdata = {4'd0, out_count, out_data};
	assign m_tuser = {out_bad, out_mism, out_end};

endmodule
